[rtl/bc_pkg.sv]
// ----------------------------------------------------------------------------
// bc_pkg
// Shared widths, state codes and the command and status bundles that pass
// between the binomial coefficient controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

  localparam int FIELD_W   = 6;
  localparam int COEF_W    = 60;
  localparam int PROD_W    = 70;
  localparam int DCNT_W    = $clog2(PROD_W);
  localparam int MAX_N_DEF = 63;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_TEST = 3'd1;
  localparam logic [STATE_W-1:0] ST_MUL  = 3'd2;
  localparam logic [STATE_W-1:0] ST_DIV  = 3'd3;
  localparam logic [STATE_W-1:0] ST_PUSH = 3'd4;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic steps_done;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/bc_ctrl.sv]
// ----------------------------------------------------------------------------
// bc_ctrl
// Sequencer for the binomial coefficient: one multiply and one bit-serial
// exact division per step, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output bc_pkg::cmd_t      cmd,
  input  wire bc_pkg::sts_t sts
);

  logic [bc_pkg::STATE_W-1:0] state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       push_ok;

  assign in_stall  = (state_r != bc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign push_ok   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      bc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bc_pkg::ST_TEST;
        end
      end
      bc_pkg::ST_TEST: begin
        state_nxt = sts.steps_done ? bc_pkg::ST_PUSH : bc_pkg::ST_MUL;
      end
      bc_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bc_pkg::ST_DIV;
      end
      bc_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = bc_pkg::ST_TEST;
        end
      end
      bc_pkg::ST_PUSH: begin
        if (push_ok) begin
          cmd.push  = 1'b1;
          state_nxt = bc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.push | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bc_datapath.sv]
// ----------------------------------------------------------------------------
// bc_datapath
// Running product, step counter, narrow multiplier, restoring divider that
// retires one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_datapath #(
  parameter int MAX_N = bc_pkg::MAX_N_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bc_pkg::FIELD_W-1:0] in_n_total,
  input  wire logic [bc_pkg::FIELD_W-1:0] in_choose_count,
  output logic      [bc_pkg::COEF_W-1:0]  out_coefficient,
  input  wire bc_pkg::cmd_t               cmd,
  output bc_pkg::sts_t                    sts
);

  localparam int FW = bc_pkg::FIELD_W;
  localparam int PW = bc_pkg::PROD_W;
  localparam int CW = bc_pkg::DCNT_W;

  logic [PW-1:0] acc_r, acc_nxt;
  logic [FW-1:0] held_n_r, held_n_nxt;
  logic [FW-1:0] eff_r_r, eff_r_nxt;
  logic [FW-1:0] step_r, step_nxt;
  logic [FW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dcnt_r, dcnt_nxt;
  logic [bc_pkg::COEF_W-1:0] coef_r, coef_nxt;

  logic          bad_in;
  logic [FW-1:0] comp_r;
  logic [FW-1:0] factor;
  logic [FW-1:0] divisor;
  logic [PW+FW-1:0] prod;
  logic [FW:0]   trial;
  logic          qbit;

  assign bad_in  = (in_choose_count > in_n_total) ||
                   ({1'b0, in_n_total} > (FW+1)'(MAX_N));
  assign comp_r  = in_n_total - in_choose_count;
  assign factor  = held_n_r - step_r;
  assign divisor = step_r + FW'(1);
  assign prod    = acc_r * factor;
  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign trial   = {rem_r, acc_r[PW-1]};
  assign qbit    = (trial >= {1'b0, divisor});

  assign sts.steps_done = (step_r == eff_r_r);
  assign sts.div_last   = (dcnt_r == CW'(PW-1));

  always_comb begin
    acc_nxt    = acc_r;
    held_n_nxt = held_n_r;
    eff_r_nxt  = eff_r_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    coef_nxt   = coef_r;
    if (cmd.load) begin
      held_n_nxt = in_n_total;
      step_nxt   = '0;
      if (bad_in) begin
        eff_r_nxt = '0;
        acc_nxt   = '0;
      end else begin
        eff_r_nxt = (in_choose_count > comp_r) ? comp_r : in_choose_count;
        acc_nxt   = PW'(1);
      end
    end
    if (cmd.mul) begin
      acc_nxt  = prod[PW-1:0];
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end
    if (cmd.div) begin
      // The quotient bits fill in from the bottom as the dividend leaves the top.
      acc_nxt  = {acc_r[PW-2:0], qbit};
      rem_nxt  = qbit ? FW'(trial - {1'b0, divisor}) : trial[FW-1:0];
      dcnt_nxt = dcnt_r + CW'(1);
      if (sts.div_last) begin
        step_nxt = step_r + FW'(1);
      end
    end
    if (cmd.push) begin
      coef_nxt = acc_r[bc_pkg::COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      held_n_r <= '0;
      step_r   <= '0;
      eff_r_r  <= '0;
      dcnt_r   <= '0;
    end else begin
      acc_r    <= acc_nxt;
      held_n_r <= held_n_nxt;
      step_r   <= step_nxt;
      eff_r_r  <= eff_r_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    coef_r   <= coef_nxt;
  end

  assign out_coefficient = coef_r;

endmodule

`default_nettype wire

[rtl/binomial_coefficient.sv]
// Steps: one per unit of k = min(r, n - r), none in a trivial case.
// Throughput: one item at a time; each step is one multiply, an exact division
// by the one-bit-per-cycle divider, and one check.
// Reset: synchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
// binomial_coefficient
// Computes n choose r with a shared multiplier and a bit-serial exact divider;
// gives zero when r exceeds n or n exceeds MAX_N.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient #(
  parameter int MAX_N = bc_pkg::MAX_N_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bc_pkg::FIELD_W-1:0] in_n_total,
  input  wire logic [bc_pkg::FIELD_W-1:0] in_choose_count,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [bc_pkg::COEF_W-1:0]  out_coefficient
);

  bc_pkg::cmd_t cmd;
  bc_pkg::sts_t sts;

  bc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bc_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_n_total      (in_n_total),
    .in_choose_count (in_choose_count),
    .out_coefficient (out_coefficient),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
